### rtl/script_markup_tokenizer_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the markup tokenizer
// Shared immediate-style wrappers around concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef SCRIPT_MARKUP_TOKENIZER_UNIT_ASSERT_SVH
`define SCRIPT_MARKUP_TOKENIZER_UNIT_ASSERT_SVH

// condition must hold at every edge outside reset
`define SMT_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// pre in this cycle implies post in the next cycle
`define SMT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/smt_pkg.sv
// ----------------------------------------------------------------------------
// smt_pkg
// Types, character codes and classifier functions for the markup tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package smt_pkg;

    localparam int OFFSET_BITS_DEF = 24;
    localparam int LINE_BITS_DEF   = 20;
    localparam int COLUMN_BITS_DEF = 16;
    localparam int CP_BITS         = 21;
    localparam int KIND_BITS       = 4;

    localparam logic [CP_BITS-1:0] CH_LBRACKET = 21'h00005B;
    localparam logic [CP_BITS-1:0] CH_RBRACKET = 21'h00005D;
    localparam logic [CP_BITS-1:0] CH_LBRACE   = 21'h00007B;
    localparam logic [CP_BITS-1:0] CH_RBRACE   = 21'h00007D;
    localparam logic [CP_BITS-1:0] CH_COMMA    = 21'h00002C;
    localparam logic [CP_BITS-1:0] CH_EQUALS   = 21'h00003D;
    localparam logic [CP_BITS-1:0] CH_COLON    = 21'h00003A;
    localparam logic [CP_BITS-1:0] CH_LF       = 21'h00000A;
    localparam logic [CP_BITS-1:0] CH_TAB      = 21'h000009;
    localparam logic [CP_BITS-1:0] CH_CR       = 21'h00000D;
    localparam logic [CP_BITS-1:0] CH_VT       = 21'h00000B;
    localparam logic [CP_BITS-1:0] CH_FF       = 21'h00000C;
    localparam logic [CP_BITS-1:0] CH_SPACE    = 21'h000020;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_NEWLINE  = 4'd0,
        KIND_LBRACKET = 4'd1,
        KIND_RBRACKET = 4'd2,
        KIND_LBRACE   = 4'd3,
        KIND_RBRACE   = 4'd4,
        KIND_LDOUBLE  = 4'd5,
        KIND_RDOUBLE  = 4'd6,
        KIND_COLON    = 4'd7,
        KIND_EQUALS   = 4'd8,
        KIND_COMMA    = 4'd9,
        KIND_LITERAL  = 4'd10
    } kind_t;

    typedef enum logic [1:0] {
        PH_BETWEEN = 2'd0,
        PH_ENTRY   = 2'd1,
        PH_LITERAL = 2'd2,
        PH_SKIP    = 2'd3
    } phase_t;

    typedef struct packed {
        logic   plain;
        logic   comment;
        phase_t phase;
    } ctl_t;

    localparam ctl_t CTL_RESET = '{plain: 1'b1, comment: 1'b0, phase: PH_BETWEEN};

    function automatic logic is_blank(input logic [CP_BITS-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

    function automatic logic is_brace(input logic [CP_BITS-1:0] c);
        return (c == CH_LBRACE) || (c == CH_RBRACE);
    endfunction

    function automatic logic is_tokchar(input logic [CP_BITS-1:0] c);
        return (c == CH_LBRACKET) || (c == CH_RBRACKET) || is_brace(c) ||
               (c == CH_COMMA) || (c == CH_EQUALS) || (c == CH_COLON);
    endfunction

endpackage

`default_nettype wire

### rtl/smt_step.sv
// ----------------------------------------------------------------------------
// smt_step
// Decides one character against its look-ahead: up to two tokens and the
// updated scanner state.
// ----------------------------------------------------------------------------
`default_nettype none

module smt_step #(
    parameter int OFFSET_BITS = smt_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS   = smt_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = smt_pkg::COLUMN_BITS_DEF,
    parameter int TOK_W       = smt_pkg::KIND_BITS + LINE_BITS + COLUMN_BITS + 2 * OFFSET_BITS
) (
    input  smt_pkg::ctl_t                ctl,
    input  logic [LINE_BITS-1:0]         line,
    input  logic [COLUMN_BITS-1:0]       col,
    input  logic [OFFSET_BITS-1:0]       off,
    input  logic [OFFSET_BITS-1:0]       lit_off,
    input  logic [LINE_BITS-1:0]         lit_line,
    input  logic [COLUMN_BITS-1:0]       lit_col,
    input  logic [OFFSET_BITS-1:0]       blanks,
    input  logic [smt_pkg::CP_BITS-1:0]  c,
    input  logic [smt_pkg::CP_BITS-1:0]  n,
    input  logic                         at_end,
    output smt_pkg::ctl_t                ctl_nx,
    output logic [LINE_BITS-1:0]         line_nx,
    output logic [COLUMN_BITS-1:0]       col_nx,
    output logic [OFFSET_BITS-1:0]       off_nx,
    output logic [OFFSET_BITS-1:0]       lit_off_nx,
    output logic [LINE_BITS-1:0]         lit_line_nx,
    output logic [COLUMN_BITS-1:0]       lit_col_nx,
    output logic [OFFSET_BITS-1:0]       blanks_nx,
    output logic [1:0]                   tok_cnt,
    output logic [TOK_W-1:0]             tok0,
    output logic [TOK_W-1:0]             tok1
);
    import smt_pkg::*;

    logic                   c_blank;
    logic                   c_nl;
    logic                   pair;
    logic                   pair_brace;
    logic                   lit_close;
    logic                   btw;
    logic                   c_tok;
    kind_t                  btok_kind;
    logic                   btok_valid;
    logic [OFFSET_BITS-1:0] btok_len;
    logic                   lit_begin;
    logic                   lit_cont;
    logic                   check;
    logic                   stop;
    logic [OFFSET_BITS-1:0] eff_blanks;
    logic [OFFSET_BITS:0]   end_pos;
    logic [OFFSET_BITS:0]   span;
    logic [OFFSET_BITS:0]   lit_len_raw;
    logic [OFFSET_BITS-1:0] lit_len;
    logic                   lit_valid;
    logic [TOK_W-1:0]       lit_tok;
    logic [TOK_W-1:0]       btok_tok;
    logic [TOK_W-1:0]       nl_tok;

    assign c_blank    = is_blank(c);
    assign c_nl       = (c == CH_LF);
    assign pair       = !at_end && (n == c);
    assign pair_brace = is_brace(c) && pair;
    assign lit_close  = (ctl.phase == PH_LITERAL) && ctl.comment && (c == CH_RBRACE) &&
                        !at_end && (n == CH_RBRACE);
    assign btw        = (ctl.phase == PH_BETWEEN) || lit_close;

    always_comb
    begin
        c_tok     = 1'b0;
        btok_kind = KIND_LBRACKET;
        case (c)
            CH_LBRACKET:
            begin
                c_tok     = 1'b1;
                btok_kind = KIND_LBRACKET;
            end
            CH_RBRACKET:
            begin
                c_tok     = 1'b1;
                btok_kind = KIND_RBRACKET;
            end
            CH_LBRACE:
            begin
                c_tok     = 1'b1;
                btok_kind = pair ? KIND_LDOUBLE : KIND_LBRACE;
            end
            CH_RBRACE:
            begin
                c_tok     = 1'b1;
                btok_kind = pair ? KIND_RDOUBLE : KIND_RBRACE;
            end
            CH_COLON:
            begin
                c_tok     = !ctl.plain;
                btok_kind = KIND_COLON;
            end
            CH_EQUALS:
            begin
                c_tok     = !ctl.plain;
                btok_kind = KIND_EQUALS;
            end
            CH_COMMA:
            begin
                c_tok     = !ctl.plain;
                btok_kind = KIND_COMMA;
            end
            default:
            begin
                c_tok     = 1'b0;
                btok_kind = KIND_LBRACKET;
            end
        endcase
    end

    assign btok_valid = btw && c_tok;
    assign btok_len   = pair_brace ? OFFSET_BITS'(2) : OFFSET_BITS'(1);

    // a literal opens on the first non-blank: non-token, or any in PH_ENTRY
    assign lit_begin = !c_blank && (((ctl.phase == PH_BETWEEN) && !c_tok) ||
                                    (ctl.phase == PH_ENTRY));
    assign lit_cont  = (ctl.phase == PH_LITERAL) && !lit_close;
    assign check     = lit_begin || lit_cont;

    assign stop = at_end || (n == CH_LF) ||
                  (ctl.plain ? (!ctl.comment && is_brace(n)) : is_tokchar(n));

    assign lit_off_nx  = lit_begin ? off  : lit_off;
    assign lit_line_nx = lit_begin ? line : lit_line;
    assign lit_col_nx  = lit_begin ? col  : lit_col;

    always_comb
    begin
        if (lit_begin)
            eff_blanks = '0;
        else if (lit_cont)
            eff_blanks = c_blank ? ((blanks == '1) ? blanks : blanks + 1'b1) : '0;
        else
            eff_blanks = blanks;
    end
    assign blanks_nx = eff_blanks;

    // closing double brace ends the literal before the brace itself
    assign end_pos     = lit_close ? {1'b0, off} : {1'b0, off} + 1'b1;
    assign span        = (end_pos > {1'b0, lit_off_nx}) ? end_pos - {1'b0, lit_off_nx} : '0;
    assign lit_len_raw = span - {1'b0, eff_blanks};
    assign lit_len     = lit_len_raw[OFFSET_BITS] ? '1 : lit_len_raw[OFFSET_BITS-1:0];
    assign lit_valid   = (lit_close || (check && stop)) && (span > {1'b0, eff_blanks});

    assign lit_tok  = {KIND_LITERAL, lit_line_nx, lit_col_nx, lit_off_nx, lit_len};
    assign btok_tok = {btok_kind, line, col, off, btok_len};
    assign nl_tok   = {KIND_NEWLINE, line, col, off, {OFFSET_BITS{1'b0}}};

    // a newline token, when present, always comes last
    assign tok_cnt = 2'(lit_valid) + 2'(btok_valid) + 2'(c_nl);
    assign tok0    = lit_valid ? lit_tok : (btok_valid ? btok_tok : nl_tok);
    assign tok1    = (lit_valid && btok_valid) ? btok_tok : nl_tok;

    assign line_nx = (c_nl && (line != '1)) ? line + 1'b1 : line;
    assign col_nx  = c_nl ? COLUMN_BITS'(1) : ((col == '1) ? col : col + 1'b1);
    assign off_nx  = (off == '1) ? off : off + 1'b1;

    always_comb
    begin
        ctl_nx = ctl;
        if (btw)
        begin
            case (c)
                CH_LBRACKET: ctl_nx.plain = 1'b0;
                CH_RBRACKET: ctl_nx.plain = 1'b1;
                CH_LBRACE:
                begin
                    if (pair)
                        ctl_nx.comment = 1'b1;
                    else
                        ctl_nx.plain = 1'b0;
                end
                CH_RBRACE:
                begin
                    if (pair)
                        ctl_nx.comment = 1'b0;
                    else
                        ctl_nx.plain = 1'b1;
                end
                default: ctl_nx.plain = ctl.plain;
            endcase
        end

        if (check)
            ctl_nx.phase = stop ? PH_BETWEEN : PH_LITERAL;
        else if (btw)
            ctl_nx.phase = pair_brace ? PH_SKIP : PH_BETWEEN;
        else if (ctl.phase == PH_ENTRY)
            ctl_nx.phase = PH_ENTRY;
        else
            ctl_nx.phase = ctl.comment ? PH_ENTRY : PH_BETWEEN;
    end

endmodule

`default_nettype wire

### rtl/smt_resbuf.sv
// ----------------------------------------------------------------------------
// smt_resbuf
// Three-entry result buffer: loaded with all tokens of one input word,
// drained one token per output word.
// ----------------------------------------------------------------------------
`default_nettype none

`include "script_markup_tokenizer_unit_assert.svh"

module smt_resbuf #(
    parameter int TOK_W = smt_pkg::KIND_BITS + smt_pkg::LINE_BITS_DEF +
                          smt_pkg::COLUMN_BITS_DEF + 2 * smt_pkg::OFFSET_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic [1:0]       load_cnt,
    input  logic [TOK_W-1:0] slot0,
    input  logic [TOK_W-1:0] slot1,
    input  logic [TOK_W-1:0] slot2,
    input  logic             out_stall,
    output logic             free,
    output logic             out_valid,
    output logic             out_last,
    output logic [TOK_W-1:0] out_tok
);
    import smt_pkg::*;

    logic [TOK_W-1:0] slot_reg [3];
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    logic [1:0]       idx_reg;
    logic [1:0]       idx_next;
    logic             pop;
    logic [2:0]       idx_sum;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_last  = (cnt_reg == 2'd1);
    assign out_tok   = slot_reg[idx_reg];
    assign pop       = out_valid && !out_stall;
    assign free      = (cnt_reg == 2'd0) || (out_last && !out_stall);

    always_comb
    begin
        if (load)
        begin
            cnt_next = load_cnt;
            idx_next = 2'd0;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - 2'd1;
            idx_next = idx_reg + 2'd1;
        end
        else
        begin
            cnt_next = cnt_reg;
            idx_next = idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg[0] <= slot0;
            slot_reg[1] <= slot1;
            slot_reg[2] <= slot2;
        end
    end

    assign idx_sum = {1'b0, idx_reg} + {1'b0, cnt_reg};

    `SMT_ASSERT_ALWAYS(a_idx_in_range, clk, rst_n, idx_sum <= 3'd3, "read index past loaded tokens")
    `SMT_ASSERT_NEXT(a_load_shows, clk, rst_n, load && (load_cnt != 2'd0), out_valid && (idx_reg == 2'd0), "loaded tokens not presented from the first slot")
    `SMT_ASSERT_NEXT(a_pop_counts, clk, rst_n, pop && !load, cnt_reg == $past(cnt_reg) - 2'd1, "taken word not removed from buffer")

endmodule

`default_nettype wire

### rtl/script_markup_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// script_markup_tokenizer_unit
// Streaming tokenizer for a bracket/brace markup script, one code point in,
// zero to three position-tagged tokens out.
// ----------------------------------------------------------------------------
//  Channel | Dir | Handshake           | Word
//  --------+-----+---------------------+--------------------------------------
//  in      | in  | in_valid / in_stall | code_point, end_of_source
//  out     | out | out_valid/out_stall | token_kind, start_*, token_length,
//          |     |                     | last_of_run
//
//  One code point per cycle is taken while each word yields at most one token
//  and out_stall is low; a word yielding more tokens holds the input register
//  until the single-token-per-cycle drain of the 3-entry result buffer frees it.
//  Accepted words wait in the input register, their tokens then in the result buffer.
//  Reset returns the scanner to the start of a source; end_of_source does the
//  same after its tokens are queued.
//  in_stall follows out_stall combinationally when the buffer holds its last token.
// ----------------------------------------------------------------------------
`default_nettype none

`include "script_markup_tokenizer_unit_assert.svh"

module script_markup_tokenizer_unit #(
    parameter int OFFSET_BITS = smt_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS   = smt_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = smt_pkg::COLUMN_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [smt_pkg::CP_BITS-1:0]   code_point,
    input  logic                          end_of_source,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [smt_pkg::KIND_BITS-1:0] token_kind,
    output logic [LINE_BITS-1:0]          start_line,
    output logic [COLUMN_BITS-1:0]        start_column,
    output logic [OFFSET_BITS-1:0]        start_offset,
    output logic [OFFSET_BITS-1:0]        token_length,
    output logic                          last_of_run
);
    import smt_pkg::*;

    localparam int TOK_W    = KIND_BITS + LINE_BITS + COLUMN_BITS + 2 * OFFSET_BITS;
    localparam int OFF_LSB  = OFFSET_BITS;
    localparam int COL_LSB  = 2 * OFFSET_BITS;
    localparam int LINE_LSB = 2 * OFFSET_BITS + COLUMN_BITS;
    localparam int KIND_LSB = 2 * OFFSET_BITS + COLUMN_BITS + LINE_BITS;

    // input register
    logic                   in_full_reg;
    logic                   in_full_next;
    logic [CP_BITS-1:0]     in_cp_reg;
    logic                   in_eos_reg;
    logic                   accept;
    logic                   load;
    logic                   free;

    // scanner state
    logic [CP_BITS-1:0]     held_reg;
    logic [CP_BITS-1:0]     held_next;
    logic                   held_valid_reg;
    logic                   held_valid_next;
    ctl_t                   ctl_reg;
    ctl_t                   ctl_next;
    logic [LINE_BITS-1:0]   line_reg;
    logic [LINE_BITS-1:0]   line_next;
    logic [COLUMN_BITS-1:0] col_reg;
    logic [COLUMN_BITS-1:0] col_next;
    logic [OFFSET_BITS-1:0] off_reg;
    logic [OFFSET_BITS-1:0] off_next;
    logic [OFFSET_BITS-1:0] lit_off_reg;
    logic [OFFSET_BITS-1:0] lit_off_next;
    logic [LINE_BITS-1:0]   lit_line_reg;
    logic [LINE_BITS-1:0]   lit_line_next;
    logic [COLUMN_BITS-1:0] lit_col_reg;
    logic [COLUMN_BITS-1:0] lit_col_next;
    logic [OFFSET_BITS-1:0] blanks_reg;
    logic [OFFSET_BITS-1:0] blanks_next;

    // first step: held character against the incoming one
    ctl_t                   a_ctl;
    logic [LINE_BITS-1:0]   a_line;
    logic [COLUMN_BITS-1:0] a_col;
    logic [OFFSET_BITS-1:0] a_off;
    logic [OFFSET_BITS-1:0] a_lit_off;
    logic [LINE_BITS-1:0]   a_lit_line;
    logic [COLUMN_BITS-1:0] a_lit_col;
    logic [OFFSET_BITS-1:0] a_blanks;
    logic [1:0]             a_cnt;
    logic [TOK_W-1:0]       a_tok0;
    logic [TOK_W-1:0]       a_tok1;

    // state after the first step
    ctl_t                   s_ctl;
    logic [LINE_BITS-1:0]   s_line;
    logic [COLUMN_BITS-1:0] s_col;
    logic [OFFSET_BITS-1:0] s_off;
    logic [OFFSET_BITS-1:0] s_lit_off;
    logic [LINE_BITS-1:0]   s_lit_line;
    logic [COLUMN_BITS-1:0] s_lit_col;
    logic [OFFSET_BITS-1:0] s_blanks;

    // second step: final character with no look-ahead
    ctl_t                   b_ctl;
    logic [LINE_BITS-1:0]   b_line;
    logic [COLUMN_BITS-1:0] b_col;
    logic [OFFSET_BITS-1:0] b_off;
    logic [OFFSET_BITS-1:0] b_lit_off;
    logic [LINE_BITS-1:0]   b_lit_line;
    logic [COLUMN_BITS-1:0] b_lit_col;
    logic [OFFSET_BITS-1:0] b_blanks;
    logic [1:0]             b_cnt;
    logic [TOK_W-1:0]       b_tok0;
    logic [TOK_W-1:0]       b_tok1;

    logic [1:0]             a_cnt_eff;
    logic [1:0]             b_cnt_eff;
    logic [2:0]             tok_sum;
    logic [1:0]             load_cnt;
    logic [TOK_W-1:0]       slot0;
    logic [TOK_W-1:0]       slot1;
    logic [TOK_W-1:0]       slot2;
    logic [TOK_W-1:0]       out_tok;

    assign in_stall     = in_full_reg && !free;
    assign accept       = in_valid && !in_stall;
    assign load         = in_full_reg && free;
    assign in_full_next = accept || (in_full_reg && !load);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else
            in_full_reg <= in_full_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_cp_reg  <= code_point;
            in_eos_reg <= end_of_source;
        end
    end

    smt_step #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS),
        .TOK_W       (TOK_W)
    ) u_step_held (
        .ctl         (ctl_reg),
        .line        (line_reg),
        .col         (col_reg),
        .off         (off_reg),
        .lit_off     (lit_off_reg),
        .lit_line    (lit_line_reg),
        .lit_col     (lit_col_reg),
        .blanks      (blanks_reg),
        .c           (held_reg),
        .n           (in_cp_reg),
        .at_end      (1'b0),
        .ctl_nx      (a_ctl),
        .line_nx     (a_line),
        .col_nx      (a_col),
        .off_nx      (a_off),
        .lit_off_nx  (a_lit_off),
        .lit_line_nx (a_lit_line),
        .lit_col_nx  (a_lit_col),
        .blanks_nx   (a_blanks),
        .tok_cnt     (a_cnt),
        .tok0        (a_tok0),
        .tok1        (a_tok1)
    );

    assign s_ctl      = held_valid_reg ? a_ctl      : ctl_reg;
    assign s_line     = held_valid_reg ? a_line     : line_reg;
    assign s_col      = held_valid_reg ? a_col      : col_reg;
    assign s_off      = held_valid_reg ? a_off      : off_reg;
    assign s_lit_off  = held_valid_reg ? a_lit_off  : lit_off_reg;
    assign s_lit_line = held_valid_reg ? a_lit_line : lit_line_reg;
    assign s_lit_col  = held_valid_reg ? a_lit_col  : lit_col_reg;
    assign s_blanks   = held_valid_reg ? a_blanks   : blanks_reg;

    smt_step #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS),
        .TOK_W       (TOK_W)
    ) u_step_final (
        .ctl         (s_ctl),
        .line        (s_line),
        .col         (s_col),
        .off         (s_off),
        .lit_off     (s_lit_off),
        .lit_line    (s_lit_line),
        .lit_col     (s_lit_col),
        .blanks      (s_blanks),
        .c           (in_cp_reg),
        .n           ({CP_BITS{1'b0}}),
        .at_end      (1'b1),
        .ctl_nx      (b_ctl),
        .line_nx     (b_line),
        .col_nx      (b_col),
        .off_nx      (b_off),
        .lit_off_nx  (b_lit_off),
        .lit_line_nx (b_lit_line),
        .lit_col_nx  (b_lit_col),
        .blanks_nx   (b_blanks),
        .tok_cnt     (b_cnt),
        .tok0        (b_tok0),
        .tok1        (b_tok1)
    );

    // pack both steps' tokens into three slots; a fourth is dropped
    assign a_cnt_eff = held_valid_reg ? a_cnt : 2'd0;
    assign b_cnt_eff = in_eos_reg ? b_cnt : 2'd0;
    assign tok_sum   = {1'b0, a_cnt_eff} + {1'b0, b_cnt_eff};
    assign load_cnt  = (tok_sum > 3'd3) ? 2'd3 : tok_sum[1:0];
    assign slot0     = (a_cnt_eff != 2'd0) ? a_tok0 : b_tok0;
    assign slot1     = (a_cnt_eff == 2'd2) ? a_tok1 :
                       ((a_cnt_eff == 2'd1) ? b_tok0 : b_tok1);
    assign slot2     = (a_cnt_eff == 2'd2) ? b_tok0 : b_tok1;

    always_comb
    begin
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        ctl_next        = ctl_reg;
        line_next       = line_reg;
        col_next        = col_reg;
        off_next        = off_reg;
        lit_off_next    = lit_off_reg;
        lit_line_next   = lit_line_reg;
        lit_col_next    = lit_col_reg;
        blanks_next     = blanks_reg;
        if (load)
        begin
            if (in_eos_reg)
            begin
                held_next       = '0;
                held_valid_next = 1'b0;
                ctl_next        = CTL_RESET;
                line_next       = LINE_BITS'(1);
                col_next        = COLUMN_BITS'(1);
                off_next        = '0;
                lit_off_next    = '0;
                lit_line_next   = LINE_BITS'(1);
                lit_col_next    = COLUMN_BITS'(1);
                blanks_next     = '0;
            end
            else
            begin
                held_next       = in_cp_reg;
                held_valid_next = 1'b1;
                ctl_next        = s_ctl;
                line_next       = s_line;
                col_next        = s_col;
                off_next        = s_off;
                lit_off_next    = s_lit_off;
                lit_line_next   = s_lit_line;
                lit_col_next    = s_lit_col;
                blanks_next     = s_blanks;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            ctl_reg        <= CTL_RESET;
            line_reg       <= LINE_BITS'(1);
            col_reg        <= COLUMN_BITS'(1);
            off_reg        <= '0;
            lit_off_reg    <= '0;
            lit_line_reg   <= LINE_BITS'(1);
            lit_col_reg    <= COLUMN_BITS'(1);
            blanks_reg     <= '0;
        end
        else
        begin
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            ctl_reg        <= ctl_next;
            line_reg       <= line_next;
            col_reg        <= col_next;
            off_reg        <= off_next;
            lit_off_reg    <= lit_off_next;
            lit_line_reg   <= lit_line_next;
            lit_col_reg    <= lit_col_next;
            blanks_reg     <= blanks_next;
        end
    end

    smt_resbuf #(
        .TOK_W (TOK_W)
    ) u_resbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .load_cnt  (load_cnt),
        .slot0     (slot0),
        .slot1     (slot1),
        .slot2     (slot2),
        .out_stall (out_stall),
        .free      (free),
        .out_valid (out_valid),
        .out_last  (last_of_run),
        .out_tok   (out_tok)
    );

    assign token_kind   = out_tok[KIND_LSB +: KIND_BITS];
    assign start_line   = out_tok[LINE_LSB +: LINE_BITS];
    assign start_column = out_tok[COL_LSB +: COLUMN_BITS];
    assign start_offset = out_tok[OFF_LSB +: OFFSET_BITS];
    assign token_length = out_tok[0 +: OFFSET_BITS];

    `SMT_ASSERT_NEXT(a_eos_restarts, clk, rst_n, load && in_eos_reg, !held_valid_reg && (ctl_reg.phase == PH_BETWEEN) && (off_reg == '0), "scanner not back at source start after final word")
    `SMT_ASSERT_NEXT(a_char_held, clk, rst_n, load && !in_eos_reg, held_valid_reg && (held_reg == $past(in_cp_reg)), "incoming code point not held for look-ahead")
    `SMT_ASSERT_NEXT(a_out_held, clk, rst_n, out_valid && out_stall, out_valid && (out_tok == $past(out_tok)), "stalled output word changed")

endmodule

`default_nettype wire

### bench/tb_script_markup_tokenizer_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_script_markup_tokenizer_unit
// Self-checking bench for the markup tokenizer. A hand-written table of short
// sources comes first, followed by random sources made of words, blanks,
// punctuation, double braces and arbitrary code points. A scanner model in
// the bench predicts untyped tokens; a monitor compares all tokens in order.
// Both sides stall at random, and one long output hold backs up the input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_script_markup_tokenizer_unit;

    import smt_pkg::*;

    localparam int OFF_W  = OFFSET_BITS_DEF;
    localparam int LINE_W = LINE_BITS_DEF;
    localparam int COL_W  = COLUMN_BITS_DEF;

    localparam int DIRECTED_ROWS = 25;
    localparam int PHASE1_WORDS  = 125;
    localparam int PHASE2_WORDS  = 225;
    localparam int TOTAL_WORDS   = 330;
    localparam int HOLD_CYCLES   = 60;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [CP_BITS-1:0] LTR_A       = 21'h000061;
    localparam logic [CP_BITS-1:0] LTR_B       = 21'h000062;
    localparam logic [CP_BITS-1:0] LTR_X       = 21'h000078;
    localparam logic [CP_BITS-1:0] CP_NUL      = 21'h000000;
    localparam logic [CP_BITS-1:0] CP_TOP      = 21'h10FFFF;
    localparam logic [CP_BITS-1:0] CP_ALL_ONES = 21'h1FFFFF;

    localparam logic [CP_BITS-1:0] BLANKS [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
    localparam logic [CP_BITS-1:0] PUNCT [7] = '{CH_LBRACKET, CH_RBRACKET, CH_LBRACE,
                                                 CH_RBRACE, CH_COLON, CH_EQUALS, CH_COMMA};

    typedef struct packed {
        kind_t              kind;
        logic [LINE_W-1:0]  ln;
        logic [COL_W-1:0]   col;
        logic [OFF_W-1:0]   off;
        logic [OFF_W-1:0]   len;
        logic               run_end;
    } token_t;

    localparam token_t NO_TOKEN = '0;

    function automatic token_t fixed_token(kind_t k, int ln, int cl, int of, int len);
        token_t t;
        t.kind    = k;
        t.ln      = ln[LINE_W-1:0];
        t.col     = cl[COL_W-1:0];
        t.off     = of[OFF_W-1:0];
        t.len     = len[OFF_W-1:0];
        t.run_end = 1'b1;
        return t;
    endfunction

    typedef struct {
        logic [CP_BITS-1:0] cp;
        logic               eos;
        logic               typed;
        token_t             tok;
    } script_row_t;

    // typed rows carry the single token that the word completes
    script_row_t script_rows [DIRECTED_ROWS] = '{
        '{CH_LBRACKET, 1'b0, 1'b0, NO_TOKEN},
        '{CH_COLON,    1'b0, 1'b1, fixed_token(KIND_LBRACKET, 1, 1, 0, 1)},
        '{CH_EQUALS,   1'b0, 1'b1, fixed_token(KIND_COLON,    1, 2, 1, 1)},
        '{CH_COMMA,    1'b0, 1'b1, fixed_token(KIND_EQUALS,   1, 3, 2, 1)},
        '{CH_LBRACE,   1'b0, 1'b1, fixed_token(KIND_COMMA,    1, 4, 3, 1)},
        '{CP_NUL,      1'b0, 1'b1, fixed_token(KIND_LBRACE,   1, 5, 4, 1)},
        '{CP_TOP,      1'b0, 1'b0, NO_TOKEN},
        '{CH_SPACE,    1'b0, 1'b0, NO_TOKEN},
        '{CH_RBRACKET, 1'b0, 1'b1, fixed_token(KIND_LITERAL,  1, 6, 5, 2)},
        '{CH_LF,       1'b0, 1'b1, fixed_token(KIND_RBRACKET, 1, 9, 8, 1)},
        '{CH_LBRACE,   1'b0, 1'b1, fixed_token(KIND_NEWLINE,  1, 10, 9, 0)},
        '{CH_LBRACE,   1'b0, 1'b1, fixed_token(KIND_LDOUBLE,  2, 1, 10, 2)},
        '{CH_SPACE,    1'b0, 1'b0, NO_TOKEN},
        '{CH_LF,       1'b0, 1'b0, NO_TOKEN},
        '{CH_LBRACKET, 1'b0, 1'b1, fixed_token(KIND_NEWLINE,  2, 4, 13, 0)},
        '{LTR_X,       1'b0, 1'b0, NO_TOKEN},
        '{CH_RBRACE,   1'b0, 1'b0, NO_TOKEN},
        '{CH_RBRACE,   1'b0, 1'b0, NO_TOKEN},
        '{LTR_A,       1'b0, 1'b0, NO_TOKEN},
        '{LTR_B,       1'b1, 1'b1, fixed_token(KIND_LITERAL,  3, 5, 18, 2)},
        '{CH_LF,       1'b1, 1'b1, fixed_token(KIND_NEWLINE,  1, 1, 0, 0)},
        '{CH_TAB,      1'b0, 1'b0, NO_TOKEN},
        '{CH_CR,       1'b0, 1'b0, NO_TOKEN},
        '{CH_RBRACE,   1'b1, 1'b1, fixed_token(KIND_RBRACE,   1, 3, 2, 1)},
        '{CP_ALL_ONES, 1'b1, 1'b1, fixed_token(KIND_LITERAL,  1, 1, 0, 1)}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [CP_BITS-1:0]    code_point;
    logic                  end_of_source;
    logic                  out_valid;
    logic                  out_stall;
    logic [KIND_BITS-1:0]  token_kind;
    logic [LINE_W-1:0]     start_line;
    logic [COL_W-1:0]      start_column;
    logic [OFF_W-1:0]      start_offset;
    logic [OFF_W-1:0]      token_length;
    logic                  last_of_run;

    script_markup_tokenizer_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .code_point    (code_point),
        .end_of_source (end_of_source),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .token_kind    (token_kind),
        .start_line    (start_line),
        .start_column  (start_column),
        .start_offset  (start_offset),
        .token_length  (token_length),
        .last_of_run   (last_of_run)
    );

    token_t token_q [$];
    token_t word_tokens [$];

    int errors         = 0;
    int words_sent     = 0;
    int sources_sent   = 0;
    int tokens_checked = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_requests  = 0;
    int holds_served   = 0;

    // ------------------------------------------------------------------
    // Scanner model
    // ------------------------------------------------------------------
    logic [CP_BITS-1:0] pend_cp;
    logic               pend_ok;
    logic               in_text;
    logic               in_remark;
    phase_t             scan_st;
    logic [OFF_W-1:0]   lit_off;
    logic [LINE_W-1:0]  lit_line;
    logic [COL_W-1:0]   lit_col;
    logic [OFF_W-1:0]   blank_run;
    logic [LINE_W-1:0]  pos_line;
    logic [COL_W-1:0]   pos_col;
    logic [OFF_W-1:0]   pos_off;

    function automatic logic blank_char(logic [CP_BITS-1:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
    endfunction

    function automatic logic brace_char(logic [CP_BITS-1:0] c);
        return c inside {CH_LBRACE, CH_RBRACE};
    endfunction

    function automatic logic punct_char(logic [CP_BITS-1:0] c);
        return c inside {CH_LBRACKET, CH_RBRACKET, CH_LBRACE, CH_RBRACE,
                         CH_COMMA, CH_EQUALS, CH_COLON};
    endfunction

    function automatic void clear_scanner();
        pend_cp   = '0;
        pend_ok   = 1'b0;
        in_text   = 1'b1;
        in_remark = 1'b0;
        scan_st   = PH_BETWEEN;
        lit_off   = '0;
        lit_line  = LINE_W'(1);
        lit_col   = COL_W'(1);
        blank_run = '0;
        pos_line  = LINE_W'(1);
        pos_col   = COL_W'(1);
        pos_off   = '0;
    endfunction

    // at most three tokens per word; longer lengths clamp to the offset range
    function automatic void push_token(kind_t k, logic [LINE_W-1:0] ln, logic [COL_W-1:0] cl,
                                       logic [OFF_W-1:0] of, logic [OFF_W:0] len);
        token_t t;
        if (word_tokens.size() >= 3)
            return;
        t.kind    = k;
        t.ln      = ln;
        t.col     = cl;
        t.off     = of;
        t.len     = len[OFF_W] ? '1 : len[OFF_W-1:0];
        t.run_end = 1'b0;
        word_tokens = {word_tokens, t};
    endfunction

    function automatic void push_token_here(kind_t k, logic [OFF_W:0] len);
        push_token(k, pos_line, pos_col, pos_off, len);
    endfunction

    function automatic void step_position(logic [CP_BITS-1:0] c);
        if (c == CH_LF)
        begin
            push_token_here(KIND_NEWLINE, '0);
            if (pos_line != '1)
                pos_line++;
            pos_col = COL_W'(1);
        end
        else if (pos_col != '1)
        begin
            pos_col++;
        end
        if (pos_off != '1)
            pos_off++;
    endfunction

    function automatic void close_literal(logic [OFF_W:0] end_pos);
        logic [OFF_W:0] span;
        span = (end_pos > {1'b0, lit_off}) ? end_pos - {1'b0, lit_off} : '0;
        if (span > {1'b0, blank_run})
            push_token(KIND_LITERAL, lit_line, lit_col, lit_off, span - {1'b0, blank_run});
    endfunction

    function automatic void decide_literal_end(logic [CP_BITS-1:0] c, logic [CP_BITS-1:0] n,
                                               logic at_end);
        logic stop;
        if (at_end || n == CH_LF)
            stop = 1'b1;
        else if (in_text)
            stop = !in_remark && brace_char(n);
        else
            stop = punct_char(n);
        if (stop)
        begin
            close_literal({1'b0, pos_off} + 1'b1);
            scan_st = PH_BETWEEN;
        end
        else
        begin
            scan_st = PH_LITERAL;
        end
        step_position(c);
    endfunction

    function automatic void open_literal(logic [CP_BITS-1:0] c, logic [CP_BITS-1:0] n,
                                         logic at_end);
        lit_off   = pos_off;
        lit_line  = pos_line;
        lit_col   = pos_col;
        blank_run = '0;
        decide_literal_end(c, n, at_end);
    endfunction

    function automatic void tokenize_between(logic [CP_BITS-1:0] c, logic [CP_BITS-1:0] n,
                                             logic at_end);
        logic  pair;
        kind_t kind;
        pair = !at_end && n == c;
        if (blank_char(c))
        begin
            step_position(c);
            return;
        end
        if (c == CH_LBRACKET || c == CH_RBRACKET)
        begin
            push_token_here(c == CH_LBRACKET ? KIND_LBRACKET : KIND_RBRACKET,
                            (OFF_W+1)'(1));
            in_text = (c == CH_RBRACKET);
            step_position(c);
            return;
        end
        if (brace_char(c))
        begin
            if (pair)
            begin
                push_token_here(c == CH_LBRACE ? KIND_LDOUBLE : KIND_RDOUBLE, (OFF_W+1)'(2));
                in_remark = (c == CH_LBRACE);
                scan_st   = PH_SKIP;
            end
            else
            begin
                push_token_here(c == CH_LBRACE ? KIND_LBRACE : KIND_RBRACE, (OFF_W+1)'(1));
                in_text = (c == CH_RBRACE);
            end
            step_position(c);
            return;
        end
        // separators are plain characters inside text
        if (!in_text && c inside {CH_COLON, CH_EQUALS, CH_COMMA})
        begin
            kind = (c == CH_COLON) ? KIND_COLON : (c == CH_EQUALS) ? KIND_EQUALS : KIND_COMMA;
            push_token_here(kind, (OFF_W+1)'(1));
            step_position(c);
            return;
        end
        open_literal(c, n, at_end);
    endfunction

    function automatic void decide_char(logic [CP_BITS-1:0] c, logic [CP_BITS-1:0] n,
                                        logic at_end);
        case (scan_st)
            PH_BETWEEN:
                tokenize_between(c, n, at_end);
            PH_ENTRY:
                if (blank_char(c))
                    step_position(c);
                else
                    open_literal(c, n, at_end);
            PH_LITERAL:
                if (in_remark && c == CH_RBRACE && !at_end && n == CH_RBRACE)
                begin
                    // closing double brace ends a comment literal before itself
                    close_literal({1'b0, pos_off});
                    scan_st = PH_BETWEEN;
                    tokenize_between(c, n, at_end);
                end
                else
                begin
                    if (!blank_char(c))
                        blank_run = '0;
                    else if (blank_run != '1)
                        blank_run++;
                    decide_literal_end(c, n, at_end);
                end
            default:
            begin
                scan_st = in_remark ? PH_ENTRY : PH_BETWEEN;
                step_position(c);
            end
        endcase
    endfunction

    function automatic void tokenize_word(logic [CP_BITS-1:0] cp, logic eos);
        word_tokens.delete();
        if (pend_ok)
            decide_char(pend_cp, cp, 1'b0);
        if (eos)
        begin
            decide_char(cp, '0, 1'b1);
            clear_scanner();
        end
        else
        begin
            pend_cp = cp;
            pend_ok = 1'b1;
        end
        if (word_tokens.size() > 0)
            word_tokens[word_tokens.size() - 1].run_end = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d tokens outstanding",
                     cycle_count, token_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Output side: random stalls plus one long hold
    // ------------------------------------------------------------------
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served++;
                out_stall <= 1'b1;
                for (int i = 0; i < HOLD_CYCLES; i++)
                    @(posedge clk);
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    function automatic void check_field(string field, longint unsigned want,
                                        longint unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: token %0d %s mismatch: expected %0d, actual %0d",
                     $time, tokens_checked, field, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        token_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (token_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected token: expected none, actual kind %0d offset %0d",
                         $time, token_kind, start_offset);
            end
            else
            begin
                want = token_q.pop_front();
                check_field("kind", want.kind, token_kind);
                check_field("line", want.ln, start_line);
                check_field("column", want.col, start_column);
                check_field("offset", want.off, start_offset);
                check_field("length", want.len, token_length);
                check_field("last_of_run", want.run_end, last_of_run);
            end
            tokens_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic send_word(input logic [CP_BITS-1:0] cp, input logic eos,
                             input logic typed, input token_t tok);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        code_point    <= cp;
        end_of_source <= eos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tokenize_word(cp, eos);
        if (typed)
            token_q = {token_q, tok};
        else
            token_q = {token_q, word_tokens};
        words_sent++;
    endtask

    task automatic send_random_source();
        logic [CP_BITS-1:0] src [$];
        int pieces;
        int sel;
        int run;
        pieces = $urandom_range(1, 10);
        for (int p = 0; p < pieces; p++)
        begin
            sel = $urandom_range(0, 99);
            run = $urandom_range(1, 5);
            if (sel < 30)
                repeat (run) src = {src, CP_BITS'(LTR_A + $urandom_range(0, 25))};
            else if (sel < 42)
                repeat (run) src = {src, BLANKS[$urandom_range(0, 5)]};
            else if (sel < 62)
                src = {src, PUNCT[$urandom_range(0, 6)]};
            else if (sel < 72)
                repeat (2) src = {src, CH_LBRACE};
            else if (sel < 82)
                repeat (2) src = {src, CH_RBRACE};
            else if (sel < 90)
                src = {src, CH_LF};
            else if (sel < 96)
                src = {src, CP_BITS'($urandom_range(0, CP_ALL_ONES))};
            else
                src = {src, (sel < 98) ? CP_NUL : CP_TOP};
        end
        foreach (src[i])
            send_word(src[i], i == src.size() - 1, 1'b0, NO_TOKEN);
        sources_sent++;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        code_point    = '0;
        end_of_source = 1'b0;
        clear_scanner();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 16;
        recv_idle_pct = 81;
        foreach (script_rows[i])
            send_word(script_rows[i].cp, script_rows[i].eos, script_rows[i].typed,
                      script_rows[i].tok);
        while (words_sent < PHASE1_WORDS)
            send_random_source();

        send_idle_pct = 81;
        recv_idle_pct = 16;
        while (words_sent < PHASE2_WORDS)
            send_random_source();

        // no idling; a long output hold fills the buffer and stalls the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests++;
        while (words_sent < TOTAL_WORDS)
            send_random_source();

        in_valid <= 1'b0;
        while (token_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d code points in %0d random sources after %0d table rows",
                 words_sent, sources_sent, DIRECTED_ROWS);
        $display("Checked %0d tokens, %0d field errors", tokens_checked, errors);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
